@@ hdl/fda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fda_pkg;

    // Number format: signed, FRAC_BITS fraction bits, INT_BITS integer bits
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 31;
    localparam int VAL_W     = INT_BITS + FRAC_BITS + 1;
    localparam int IP_W      = INT_BITS + 1;

    // Text limits
    localparam int MAX_DP  = 6;
    localparam int MAX_OUT = 24;

    // Power of ten, elaboration only
    function automatic longint f_pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Decimal digits needed for 2^bits - 1, elaboration only
    function automatic int f_dec_digits(input int bits);
        longint unsigned lim;
        longint unsigned p;
        int              n;
        lim = (64'd1 << bits) - 64'd1;
        p   = 64'd1;
        n   = 0;
        for (int i = 0; i < 20; i++) begin
            if (p <= lim) begin
                p = p * 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam longint SCALE_MAX = f_pow10(MAX_DP);
    localparam int FD_W      = $clog2(SCALE_MAX + 1);
    localparam int PROD_W    = FRAC_BITS + FD_W;
    localparam int INT_DIGS  = f_dec_digits(INT_BITS);
    localparam int SH_W      = (INT_BITS > FD_W) ? INT_BITS : FD_W;
    localparam int CNT_W     = $clog2(SH_W + 1);
    localparam int DP_W      = 3;
    localparam int MC_W      = 5;
    localparam int LEN_W     = $clog2(MAX_OUT + 1);
    localparam int IIDX_W    = $clog2(INT_DIGS);
    localparam int FIDX_W    = $clog2(MAX_DP);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_PLACES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS      = CFG_IDX_W'(1);
    localparam logic [DP_W-1:0]      DP_RESET           = DP_W'(2);
    localparam logic [MC_W-1:0]      MC_RESET           = MC_W'(15);

    // ASCII codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // 10^d for d in 0..MAX_DP, a small constant table
    function automatic logic [FD_W-1:0] f_scale(input logic [DP_W-1:0] d);
        logic [FD_W-1:0] s;
        s = FD_W'(1);
        for (int i = 0; i <= MAX_DP; i++) begin
            if (d == DP_W'(i)) begin
                s = FD_W'(f_pow10(i));
            end
        end
        return s;
    endfunction

    // Rounded and saturated parts of one value
    typedef struct packed {
        logic                neg;
        logic [INT_BITS-1:0] ip;
        logic [FD_W-1:0]     fd;
    } t_prep;

    // Decimal digits of one value
    typedef struct packed {
        logic                  neg;
        logic [INT_DIGS*4-1:0] ibcd;
        logic [MAX_DP*4-1:0]   fbcd;
    } t_bcd;

endpackage

`default_nettype wire

@@ hdl/fda_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fda_prep (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [fda_pkg::VAL_W-1:0]     i_value,
    input  wire  [fda_pkg::DP_W-1:0]      i_dp,
    output logic                          o_valid,
    output fda_pkg::t_prep                o_prep
);
    import fda_pkg::*;

    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic [3:0]          r_vld;
    logic                r_neg1, r_neg2, r_neg3;
    logic [VAL_W-1:0]    r_mag;
    logic [IP_W-1:0]     r_ip2, r_ip3;
    logic [PROD_W-1:0]   r_prod;
    logic [FD_W:0]       r_fdr;
    logic                r_carry;
    t_prep               r_out;

    logic [FD_W-1:0]     w_scale;
    logic [PROD_W:0]     w_sum;
    logic [FD_W:0]       w_fdr;
    logic [FD_W:0]       w_fd1;
    logic [IP_W-1:0]     w_ip1;
    logic                w_sat;

    assign w_scale = f_scale(i_dp);
    assign w_sum   = {1'b0, r_prod} + HALF;
    assign w_fdr   = w_sum[PROD_W:FRAC_BITS];
    assign w_fd1   = r_carry ? (r_fdr - {1'b0, w_scale}) : r_fdr;
    assign w_ip1   = r_ip3 + IP_W'(r_carry);
    assign w_sat   = w_ip1[INT_BITS];

    // Advance the stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    // Magnitude, fraction product, rounding, carry and saturation
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_start ? i_value[VAL_W-1] : r_neg1;
        if (i_start) begin
            r_mag <= i_value[VAL_W-1] ? VAL_W'(~i_value + VAL_W'(1)) : i_value;
        end
        r_neg2  <= r_neg1;
        r_ip2   <= r_mag[VAL_W-1:FRAC_BITS];
        r_prod  <= PROD_W'(r_mag[FRAC_BITS-1:0]) * PROD_W'(w_scale);
        r_neg3  <= r_neg2;
        r_ip3   <= r_ip2;
        r_fdr   <= w_fdr;
        r_carry <= (w_fdr >= {1'b0, w_scale});
        r_out.neg <= r_neg3;
        r_out.ip  <= w_sat ? {INT_BITS{1'b1}} : w_ip1[INT_BITS-1:0];
        r_out.fd  <= w_sat ? (w_scale - FD_W'(1)) : w_fd1[FD_W-1:0];
    end

    assign o_valid = r_vld[3];
    assign o_prep  = r_out;

endmodule

`default_nettype wire

@@ hdl/fda_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fda_bcd (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  fda_pkg::t_prep          i_prep,
    output logic                    o_done,
    output fda_pkg::t_bcd           o_bcd
);
    import fda_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SH_W-1:0]       r_ish;
    logic [SH_W-1:0]       r_fsh;
    logic [INT_DIGS*4-1:0] r_ibcd;
    logic [MAX_DP*4-1:0]   r_fbcd;
    logic                  r_neg;

    logic [INT_DIGS*4-1:0] w_iadj;
    logic [MAX_DP*4-1:0]   w_fadj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int k = 0; k < INT_DIGS; k++) begin
            dig = r_ibcd[k*4 +: 4];
            w_iadj[k*4 +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
        end
        for (int k = 0; k < MAX_DP; k++) begin
            dig = r_fbcd[k*4 +: 4];
            w_fadj[k*4 +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
        end
    end

    // Sequence one binary bit per cycle into both digit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SH_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift data
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_prep.neg;
            r_ish  <= SH_W'(i_prep.ip);
            r_fsh  <= SH_W'(i_prep.fd);
            r_ibcd <= '0;
            r_fbcd <= '0;
        end else if (r_busy) begin
            r_ibcd <= {w_iadj[INT_DIGS*4-2:0], r_ish[SH_W-1]};
            r_fbcd <= {w_fadj[MAX_DP*4-2:0], r_fsh[SH_W-1]};
            r_ish  <= {r_ish[SH_W-2:0], 1'b0};
            r_fsh  <= {r_fsh[SH_W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_bcd.neg  = r_neg;
    assign o_bcd.ibcd = r_ibcd;
    assign o_bcd.fbcd = r_fbcd;

endmodule

`default_nettype wire

@@ hdl/fda_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fda_emit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  fda_pkg::t_bcd              i_bcd,
    input  wire  [fda_pkg::DP_W-1:0]   i_dp,
    input  wire  [fda_pkg::LEN_W-1:0]  i_lim,
    output logic                       o_last_sent,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [7:0] out_char
    output logic                       o_m_tlast    // is_last
);
    import fda_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SIGN,
        E_INT,
        E_DOT,
        E_FRAC
    } t_state;

    t_state                r_state;
    logic [INT_DIGS*4-1:0] r_ibcd;
    logic [MAX_DP*4-1:0]   r_fbcd;
    logic [IIDX_W-1:0]     r_iidx;
    logic [FIDX_W-1:0]     r_fidx;
    logic [LEN_W-1:0]      r_cnt;
    logic [LEN_W-1:0]      r_len;
    logic                  r_tvalid;
    logic [7:0]            r_tdata;
    logic                  r_tlast;

    logic [LEN_W-1:0]      w_nint;
    logic [LEN_W:0]        w_txt;
    logic [LEN_W-1:0]      w_len;
    logic                  w_step;
    logic                  w_last;
    logic [7:0]            w_char;

    // Count integer digits without leading zeros, at least one
    always_comb begin
        w_nint = LEN_W'(1);
        for (int i = 0; i < INT_DIGS; i++) begin
            if (i_bcd.ibcd[i*4 +: 4] != 4'd0) begin
                w_nint = LEN_W'(i + 1);
            end
        end
    end

    // Text length, cut to the limit
    assign w_txt = (LEN_W + 1)'(i_bcd.neg) + (LEN_W + 1)'(w_nint)
                 + ((i_dp != '0) ? ((LEN_W + 1)'(i_dp) + (LEN_W + 1)'(1)) : '0);
    assign w_len = (w_txt > (LEN_W + 1)'(i_lim)) ? i_lim : w_txt[LEN_W-1:0];

    assign w_step = (r_state != E_IDLE) && (!r_tvalid || i_m_tready);
    assign w_last = (LEN_W'(r_cnt + LEN_W'(1)) == r_len);

    // Select the character for the current position
    always_comb begin
        case (r_state)
            E_SIGN:  w_char = CH_MINUS;
            E_INT:   w_char = CH_ZERO | {4'd0, r_ibcd[{r_iidx, 2'b00} +: 4]};
            E_DOT:   w_char = CH_DOT;
            E_FRAC:  w_char = CH_ZERO | {4'd0, r_fbcd[{r_fidx, 2'b00} +: 4]};
            default: w_char = CH_ZERO;
        endcase
    end

    // Walk sign, integer digits, point and fraction digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_cnt    <= '0;
            r_len    <= '0;
            r_iidx   <= '0;
            r_fidx   <= '0;
            r_tvalid <= 1'b0;
            r_tdata  <= '0;
            r_tlast  <= 1'b0;
        end else begin
            if (i_start) begin
                r_ibcd  <= i_bcd.ibcd;
                r_fbcd  <= i_bcd.fbcd;
                r_iidx  <= IIDX_W'(w_nint - LEN_W'(1));
                r_fidx  <= FIDX_W'(i_dp - DP_W'(1));
                r_cnt   <= '0;
                r_len   <= w_len;
                r_state <= i_bcd.neg ? E_SIGN : E_INT;
            end else if (w_step) begin
                r_cnt <= r_cnt + LEN_W'(1);
                if (w_last) begin
                    r_state <= E_IDLE;
                end else begin
                    case (r_state)
                        E_SIGN: r_state <= E_INT;
                        E_INT: begin
                            if (r_iidx == '0) begin
                                r_state <= E_DOT;
                            end else begin
                                r_iidx <= r_iidx - IIDX_W'(1);
                            end
                        end
                        E_DOT:  r_state <= E_FRAC;
                        E_FRAC: r_fidx <= r_fidx - FIDX_W'(1);
                        default: r_state <= E_IDLE;
                    endcase
                end
            end

            // Hold the output register until the transfer
            if (w_step) begin
                r_tvalid <= 1'b1;
                r_tdata  <= w_char;
                r_tlast  <= w_last;
            end else if (i_m_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    assign o_last_sent = w_step && w_last;
    assign o_m_tvalid  = r_tvalid;
    assign o_m_tdata   = r_tdata;
    assign o_m_tlast   = r_tlast;

endmodule

`default_nettype wire

@@ hdl/fixed_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// s         in         i_s_tvalid / o_s_tready  i_s_tdata[47:0] value (Q31.16)
// m         out        o_m_tvalid / i_m_tready  o_m_tdata[7:0] out_char, o_m_tlast is_last
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One value at a time: pipelined rounding, bit-serial binary to BCD conversion, then
// one character per cycle (up to 18) when the sink is ready.
// The next value is taken the cycle after its last character enters the output register.
// Synchronous active-low reset clears control and sets decimal_places 2, max_chars 15.
// A stalled sink holds the character sequencer; o_s_tready stays low until the last
// character is loaded into the output register.

module fixed_to_decimal_ascii (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    input  wire  [fda_pkg::VAL_W-1:0]       i_s_tdata,   // [47:0] value
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [7:0]                      o_m_tdata,   // [7:0] out_char
    output logic                            o_m_tlast,   // is_last
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [fda_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [fda_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fda_pkg::*;

    logic [DP_W-1:0]  r_dp;
    logic [MC_W-1:0]  r_mc;
    logic             r_busy;

    logic [DP_W-1:0]  w_dp;
    logic [LEN_W-1:0] w_lim;
    logic             w_accept;
    logic             w_prep_vld;
    t_prep            w_prep;
    logic             w_bcd_done;
    t_bcd             w_bcd;
    logic             w_last_sent;

    // Clamp the register values
    assign w_dp  = (r_dp > DP_W'(MAX_DP)) ? DP_W'(MAX_DP) : r_dp;
    assign w_lim = (r_mc == '0) ? LEN_W'(1)
                 : (LEN_W'(r_mc) > LEN_W'(MAX_OUT)) ? LEN_W'(MAX_OUT) : LEN_W'(r_mc);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_busy;
    assign w_accept    = i_s_tvalid && !r_busy;

    // Configuration writes and item tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp   <= DP_RESET;
            r_mc   <= MC_RESET;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DECIMAL_PLACES) begin
                    r_dp <= i_cfg_data[DP_W-1:0];
                end else if (i_cfg_index == CFG_MAX_CHARS) begin
                    r_mc <= i_cfg_data[MC_W-1:0];
                end
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_last_sent) begin
                r_busy <= 1'b0;
            end
        end
    end

    fda_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_s_tdata),
        .i_dp    (w_dp),
        .o_valid (w_prep_vld),
        .o_prep  (w_prep)
    );

    fda_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_prep_vld),
        .i_prep  (w_prep),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    fda_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_bcd_done),
        .i_bcd       (w_bcd),
        .i_dp        (w_dp),
        .i_lim       (w_lim),
        .o_last_sent (w_last_sent),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/fda_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fda_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    input  wire                             o_s_tready,
    input  wire                             o_m_tvalid,
    input  wire                             i_m_tready,
    input  wire  [7:0]                      o_m_tdata,
    input  wire                             o_m_tlast
);
    import fda_pkg::*;

    // One value in flight: input closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a value is in flight");

    // A character that is not the last means the text is unfinished
    a_busy_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input open in the middle of a text");

    // Only sign, point or digits appear
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == CH_MINUS || o_m_tdata == CH_DOT ||
                        (o_m_tdata >= CH_ZERO && o_m_tdata <= (CH_ZERO + 8'd9))))
        else $error("character outside the decimal set");

    // Stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind fixed_to_decimal_ascii fda_checker u_chk (.*);

`default_nettype wire
